// ----- design/mbdh_pkg.sv -----
// Shared types and constants for the multi-button debouncer with hold-off.
package mbdh_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    typedef logic [TIME_W-1:0] time_ms_t;
    typedef logic [CFG_W-1:0]  cfg_val_t;

    typedef enum logic [0:0] {
        REG_DEBOUNCE = 1'b0,
        REG_HOLDOFF  = 1'b1
    } cfg_reg_t;

    localparam cfg_val_t DEBOUNCE_RESET = 16'd20;
    localparam cfg_val_t HOLDOFF_RESET  = 16'd150;

endpackage

// ----- design/multi_button_debounce_holdoff.sv -----
// Multi-button debouncer with per-button press hold-off (top level).
//
// Each beat on the input is one poll: a millisecond time stamp and the raw
// active-low levels of NUM_BUTTONS buttons. A poll is taken every cycle in
// which in_ready is high; it sits in the input register while the lane update
// runs, and its press mask is written to the result register when the output
// can advance. Each lane does one 32-bit subtract and compare against the
// debounce time and one against the hold-off time, so throughput is one poll
// per clock while the output is taken. Configuration writes take effect on
// the next clock and should be made while no poll is in flight.
module multi_button_debounce_holdoff
    import mbdh_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  time_ms_t               now_ms,
    input  logic [NUM_BUTTONS-1:0] raw_levels,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [NUM_BUTTONS-1:0] pressed_mask,
    input  logic                   cfg_we,
    input  cfg_reg_t               cfg_index,
    input  cfg_val_t               cfg_data
);

    cfg_val_t debounce_reg;
    cfg_val_t holdoff_reg;

    logic                   s1_valid_reg;
    time_ms_t               now_reg;
    logic [NUM_BUTTONS-1:0] raw_reg;

    logic                   out_valid_reg;
    logic [NUM_BUTTONS-1:0] mask_reg;

    logic [NUM_BUTTONS-1:0] seen_level_reg;
    logic [NUM_BUTTONS-1:0] stable_level_reg;
    time_ms_t               change_time_reg [NUM_BUTTONS];
    time_ms_t               fire_time_reg   [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] seen_level_next;
    logic [NUM_BUTTONS-1:0] stable_level_next;
    logic [NUM_BUTTONS-1:0] change_upd;
    logic [NUM_BUTTONS-1:0] fire_next;

    logic advance;
    logic s2_go;

    assign advance   = !out_valid_reg || out_ready;
    assign s2_go     = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign pressed_mask = mask_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            holdoff_reg  <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_HOLDOFF:  holdoff_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg <= now_ms;
            raw_reg <= raw_levels;
        end
    end

    // Per-lane update; a fresh edge restarts the change time, so the elapsed
    // time is zero and the level cannot be accepted in the same poll.
    always_comb
    begin
        seen_level_next   = seen_level_reg;
        stable_level_next = stable_level_reg;
        change_upd        = '0;
        fire_next         = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (raw_reg[i] != seen_level_reg[i])
            begin
                change_upd[i]      = 1'b1;
                seen_level_next[i] = raw_reg[i];
            end
            else if ((now_reg - change_time_reg[i]) > time_ms_t'(debounce_reg)
                     && raw_reg[i] != stable_level_reg[i])
            begin
                stable_level_next[i] = raw_reg[i];
                if (!raw_reg[i]
                    && (now_reg - fire_time_reg[i]) > time_ms_t'(holdoff_reg))
                begin
                    fire_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_level_reg   <= '1;
            stable_level_reg <= '1;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_time_reg[i] <= '0;
                fire_time_reg[i]   <= '0;
            end
        end
        else if (s2_go)
        begin
            seen_level_reg   <= seen_level_next;
            stable_level_reg <= stable_level_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (change_upd[i])
                begin
                    change_time_reg[i] <= now_reg;
                end
                if (fire_next[i])
                begin
                    fire_time_reg[i] <= now_reg;
                end
            end
        end
    end

    // Result register; hold while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            mask_reg <= fire_next;
        end
    end

`ifndef SYNTHESIS
    a_fired_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go |=> ((pressed_mask & stable_level_reg) == '0))
        else $error("fired button does not have a low stable level");

    a_fire_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && fire_next[0]) |=> (fire_time_reg[0] == $past(now_reg)))
        else $error("fire time not recorded for lane 0");

    a_stable_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_go |=> ($stable(stable_level_reg) && $stable(seen_level_reg)))
        else $error("lane state moved without a poll");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output");
`endif

endmodule
